// ===== hdl/binary_to_decimal_text_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the binary to decimal text core
// Concurrent checks that can be compiled out by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_TEXT_CORE_ASSERT_SVH
`define BINARY_TO_DECIMAL_TEXT_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Whenever cond holds, expr must hold in the same cycle.
`define B2DT_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// Whenever cond holds, expr must hold in the following cycle.
`define B2DT_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`else

`define B2DT_ASSERT_SAME(label, clk, rst, cond, expr)
`define B2DT_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

// ===== hdl/b2dt_pkg.sv =====
// ----------------------------------------------------------------------------
// Binary to decimal text package
// Shared constants and the word type passed from the converter to the emitter.
// ----------------------------------------------------------------------------
package b2dt_pkg;

   localparam int unsigned DIGITS_MAX = 10;
   localparam int unsigned DIGIT_W    = 4;
   localparam int unsigned COUNT_W    = 4;

   localparam logic [5:0]  ASCII_ZERO = 6'd48;
   localparam logic [5:0]  ASCII_NINE = 6'd57;

   // Reciprocal of ten, scaled by 2^35: floor(v * RECIP_TEN / 2^35) == v / 10
   // for every 32-bit v.
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int unsigned RECIP_SHIFT = 35;

   typedef logic [DIGITS_MAX-1:0][DIGIT_W-1:0] digits_type;

   // Digits are held least significant first; count is the number of digits.
   typedef struct packed {
      digits_type           digits;
      logic [COUNT_W-1:0]   count;
   } entry_type;

endpackage

// ===== hdl/binary_to_decimal_text_core.sv =====
// ----------------------------------------------------------------------------
// Binary to decimal text core
// Renders an unsigned 32-bit word as ASCII decimal characters, most
// significant first, without leading zeros; zero gives a single '0'. Each
// character carries its position and the final one is flagged as last. The
// converter peels the decimal digits one at a time with its single
// divide-by-ten multiplier loop, and accepts the next word in the cycle its
// current word leaves for the queue. The emitter sends one character per
// cycle while its result stage is free or popped. A finished word is
// registered in the queue, and its first character then in the result stage.
// ----------------------------------------------------------------------------
module binary_to_decimal_text_core #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic [31:0] req_value,
   output logic        full,
   output logic        empty,
   input  logic        pop,
   output logic [5:0]  rsp_char_code,
   output logic [3:0]  rsp_position,
   output logic        rsp_last
);

   b2dt_pkg::entry_type push_data;
   b2dt_pkg::entry_type pop_data;
   logic                q_push;
   logic                q_full;
   logic                q_pop;
   logic                q_empty;

   b2dt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (push),
      .req_value (req_value),
      .req_full  (full),
      .q_push    (q_push),
      .q_data    (push_data),
      .q_full    (q_full)
   );

   b2dt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   b2dt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_data        (pop_data),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .rsp_empty     (empty),
      .rsp_pop       (pop),
      .rsp_char_code (rsp_char_code),
      .rsp_position  (rsp_position),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== hdl/b2dt_front.sv =====
// ----------------------------------------------------------------------------
// Binary to decimal converter
// Accepts a 32-bit value and peels one decimal digit per cycle by reciprocal
// multiplication, then hands the finished digit set to the queue, waiting while it is full.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_text_core_assert.svh"

module b2dt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic [31:0]         req_value,
   output logic                req_full,
   output logic                q_push,
   output b2dt_pkg::entry_type q_data,
   input  logic                q_full
);

   logic                                 busy_ff, busy_in;
   logic [31:0]                          value_ff, value_in;
   logic [b2dt_pkg::COUNT_W-1:0]         count_ff, count_in;
   b2dt_pkg::digits_type                 digits_ff, digits_in;

   logic [63:0]                          product;
   logic [31:0]                          quotient;
   logic [31:0]                          remainder;
   logic [b2dt_pkg::DIGIT_W-1:0]         digit;
   logic                                 finishing;
   logic                                 step;
   logic                                 accept;
   b2dt_pkg::digits_type                 digits_new;

   always_comb begin
      product   = 64'(value_ff) * 64'(b2dt_pkg::RECIP_TEN);
      quotient  = 32'(product >> b2dt_pkg::RECIP_SHIFT);
      remainder = value_ff - (quotient << 3) - (quotient << 1);
      digit     = remainder[b2dt_pkg::DIGIT_W-1:0];

      digits_new           = digits_ff;
      digits_new[count_ff] = digit;

      // The word is complete once the quotient runs out of digits or the tenth digit is taken.
      finishing = busy_ff && ((quotient == 32'd0) ||
                  (count_ff == b2dt_pkg::COUNT_W'(b2dt_pkg::DIGITS_MAX - 1)));
      step      = busy_ff && (!finishing || !q_full);
      req_full  = busy_ff && !(finishing && !q_full);
      accept    = req_push && !req_full;

      q_push         = finishing && !q_full;
      q_data.digits  = digits_new;
      q_data.count   = count_ff + b2dt_pkg::COUNT_W'(1);

      busy_in   = busy_ff;
      value_in  = value_ff;
      count_in  = count_ff;
      digits_in = digits_ff;
      if (step) begin
         value_in  = quotient;
         count_in  = count_ff + b2dt_pkg::COUNT_W'(1);
         digits_in = digits_new;
         if (finishing) begin
            busy_in = 1'b0;
         end
      end
      if (accept) begin
         busy_in  = 1'b1;
         value_in = req_value;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      value_ff  <= value_in;
      digits_ff <= digits_in;
   end

   `B2DT_ASSERT_SAME(a_front_count_bound, clock, reset, busy_ff,
      count_ff < b2dt_pkg::COUNT_W'(b2dt_pkg::DIGITS_MAX))
   `B2DT_ASSERT_SAME(a_front_push_complete, clock, reset, q_push,
      q_data.count >= b2dt_pkg::COUNT_W'(1))

endmodule

// ===== hdl/b2dt_queue.sv =====
// ----------------------------------------------------------------------------
// Converter to emitter queue
// A short first-in first-out buffer of digit words.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_text_core_assert.svh"

module b2dt_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b2dt_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output b2dt_pkg::entry_type pop_data,
   output logic                empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   b2dt_pkg::entry_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   always_comb begin
      full     = (count_ff == CNT_W'(DEPTH));
      empty    = (count_ff == '0);
      pop_data = mem_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `B2DT_ASSERT_SAME(a_queue_no_overflow, clock, reset, push, !full)
   `B2DT_ASSERT_SAME(a_queue_no_underflow, clock, reset, pop, !empty)

endmodule

// ===== hdl/b2dt_back.sv =====
// ----------------------------------------------------------------------------
// Decimal character emitter
// Takes digit words from the queue and, while its registered result stage is
// free or popped, sends one ASCII character per cycle, most significant first.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_text_core_assert.svh"

module b2dt_back (
   input  logic                clock,
   input  logic                reset,
   input  b2dt_pkg::entry_type q_data,
   input  logic                q_empty,
   output logic                q_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [5:0]          rsp_char_code,
   output logic [3:0]          rsp_position,
   output logic                rsp_last
);

   logic                         active_ff, active_in;
   b2dt_pkg::entry_type          cur_ff, cur_in;
   logic [b2dt_pkg::COUNT_W-1:0] pos_ff, pos_in;
   logic                         out_valid_ff, out_valid_in;
   logic [5:0]                   char_ff, char_in;
   logic [3:0]                   out_pos_ff, out_pos_in;
   logic                         last_ff, last_in;

   b2dt_pkg::entry_type          src;
   logic [b2dt_pkg::COUNT_W-1:0] k;
   logic [b2dt_pkg::COUNT_W-1:0] idx;
   logic                         out_free;
   logic                         emit;
   logic                         is_last;

   always_comb begin
      // While idle the next word is emitted straight from the queue head.
      src      = active_ff ? cur_ff : q_data;
      k        = active_ff ? pos_ff : '0;
      idx      = src.count - b2dt_pkg::COUNT_W'(1) - k;
      out_free = !out_valid_ff || rsp_pop;
      emit     = out_free && (active_ff || !q_empty);
      q_pop    = out_free && !active_ff && !q_empty;
      is_last  = (k + b2dt_pkg::COUNT_W'(1) == src.count);

      active_in    = active_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff;
      char_in      = char_ff;
      out_pos_in   = out_pos_ff;
      last_in      = last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         char_in      = b2dt_pkg::ASCII_ZERO + {2'b00, src.digits[idx]};
         out_pos_in   = k;
         last_in      = is_last;
         active_in    = !is_last;
         cur_in       = src;
         pos_in       = k + b2dt_pkg::COUNT_W'(1);
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff     <= cur_in;
      char_ff    <= char_in;
      out_pos_ff <= out_pos_in;
      last_ff    <= last_in;
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_position  = out_pos_ff;
   assign rsp_last      = last_ff;

   `B2DT_ASSERT_SAME(a_back_char_range, clock, reset, out_valid_ff,
      (char_ff >= b2dt_pkg::ASCII_ZERO) && (char_ff <= b2dt_pkg::ASCII_NINE))
   `B2DT_ASSERT_NEXT(a_back_position_step, clock, reset,
      out_valid_ff && rsp_pop && !last_ff,
      out_valid_ff && (out_pos_ff == $past(out_pos_ff) + 4'd1))

endmodule
